// ===== hw/rtl/distance_to_tone_period_core_defines.svh =====
// ----------------------------------------------------------------------------
// Distance to tone period - assertion macros
// Shared property forms for the checker of the tone period core.
// ----------------------------------------------------------------------------
`ifndef DISTANCE_TO_TONE_PERIOD_CORE_DEFINES_SVH
`define DISTANCE_TO_TONE_PERIOD_CORE_DEFINES_SVH

// Same-cycle implication, disabled during reset
`define DTP_ASSERT_NOW(lbl, clk_s, rstn_s, ante, cons, msg) \
    lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset
`define DTP_ASSERT_NEXT(lbl, clk_s, rstn_s, ante, cons, msg) \
    lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/dtp_pkg.sv =====
// ----------------------------------------------------------------------------
// Distance to tone period - package
// Types, constants and lookup tables shared by the tone period core.
// ----------------------------------------------------------------------------
`default_nettype none

package dtp_pkg;

    localparam int unsigned NUM_KEYS      = 12;
    localparam int unsigned SCALE_DEGREES = 8;

    localparam logic [7:0]  LOW_DISTANCE  = 8'd3;
    localparam logic [7:0]  HIGH_DISTANCE = 8'd10;
    localparam logic [15:0] PERIOD_MAX    = 16'hFFFF;

    // 3 MHz * 23 nominal degrees, scaled by 2^23 for the ROM formats
    localparam int unsigned NUM_W  = 50;
    localparam logic [NUM_W-1:0] PERIOD_NUM = 50'd578813952000000;

    // Quotient never exceeds 2^19 for any legal denominator
    localparam int unsigned QUO_W  = 19;
    localparam int unsigned DEN_W  = 40;
    localparam int unsigned CNT_W  = 5;

    // Shared multiplier operand widths
    localparam int unsigned MUL_A_W = 34;
    localparam int unsigned MUL_B_W = 17;
    localparam int unsigned MUL_P_W = MUL_A_W + MUL_B_W;

    // Configuration port
    localparam int unsigned CFG_IDX_W  = 1;
    localparam int unsigned CFG_DATA_W = 9;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_SELECT = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_VOLUME     = 1'b1;
    localparam logic [8:0] VOLUME_RESET = 9'd128;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL_BR,
        ST_MUL_T,
        ST_DIV_GO,
        ST_DIV_WAIT,
        ST_MUL_V,
        ST_LOAD
    } state_t;

    // Divider status seen by the sequencer
    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

    // Semitone step of each major-scale degree
    function automatic logic [3:0] degree_step(input logic [2:0] degree);
        logic [3:0] step;
        unique case (degree)
            3'd0:    step = 4'd0;
            3'd1:    step = 4'd2;
            3'd2:    step = 4'd4;
            3'd3:    step = 4'd5;
            3'd4:    step = 4'd7;
            3'd5:    step = 4'd9;
            3'd6:    step = 4'd11;
            default: step = 4'd12;
        endcase
        return step;
    endfunction

    // Key base frequency, Hz in Q9.8
    function automatic logic [16:0] base_rom(input logic [3:0] key);
        logic [16:0] f;
        unique case (key)
            4'd0:    f = 17'd56320;
            4'd1:    f = 17'd59668;
            4'd2:    f = 17'd63212;
            4'd3:    f = 17'd66977;
            4'd4:    f = 17'd70958;
            4'd5:    f = 17'd75177;
            4'd6:    f = 17'd79649;
            4'd7:    f = 17'd84385;
            4'd8:    f = 17'd89403;
            4'd9:    f = 17'd94717;
            4'd10:   f = 17'd100352;
            4'd11:   f = 17'd106317;
            default: f = 17'd56320;
        endcase
        return f;
    endfunction

    // Ratio 2^(step/12) in Q2.15
    function automatic logic [16:0] ratio_rom(input logic [3:0] step);
        logic [16:0] r;
        unique case (step)
            4'd0:    r = 17'd32768;
            4'd1:    r = 17'd34716;
            4'd2:    r = 17'd36781;
            4'd3:    r = 17'd38968;
            4'd4:    r = 17'd41285;
            4'd5:    r = 17'd43740;
            4'd6:    r = 17'd46341;
            4'd7:    r = 17'd49097;
            4'd8:    r = 17'd52016;
            4'd9:    r = 17'd55109;
            4'd10:   r = 17'd58386;
            4'd11:   r = 17'd61858;
            4'd12:   r = 17'd65536;
            default: r = 17'd32768;
        endcase
        return r;
    endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/dtp_mul.sv =====
// ----------------------------------------------------------------------------
// Distance to tone period - shared multiplier
// One registered multiplier reused for every product of the sequence.
// ----------------------------------------------------------------------------
`default_nettype none

module dtp_mul (
    input  logic                         clk,
    input  logic                         en,
    input  logic [dtp_pkg::MUL_A_W-1:0]  op_a,
    input  logic [dtp_pkg::MUL_B_W-1:0]  op_b,
    output logic [dtp_pkg::MUL_P_W-1:0]  prod
);
    import dtp_pkg::*;

    logic [MUL_P_W-1:0] prod_reg;

    // Register the product when the sequencer issues an operation
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prod_reg <= MUL_P_W'(op_a) * MUL_P_W'(op_b);
        end
    end

    assign prod = prod_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/dtp_div.sv =====
// ----------------------------------------------------------------------------
// Distance to tone period - iterative divider
// Restoring divider of the fixed period numerator, one quotient bit a cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module dtp_div (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [dtp_pkg::DEN_W-1:0]   den,
    output dtp_pkg::div_stat_t          stat,
    output logic [dtp_pkg::QUO_W-1:0]   quotient
);
    import dtp_pkg::*;

    localparam logic [QUO_W-1:0] NUM_LOW = PERIOD_NUM[QUO_W-1:0];

    logic [DEN_W-1:0] rem_reg,  rem_next;
    logic [DEN_W-1:0] den_reg,  den_next;
    logic [QUO_W-1:0] quo_reg,  quo_next;
    logic [CNT_W-1:0] cnt_reg,  cnt_next;
    logic             busy_reg, busy_next;
    logic             done_reg, done_next;

    logic [CNT_W-1:0] bit_idx;
    logic [DEN_W:0]   trial;
    logic             ge;

    // Bring down the next numerator bit and compare with the divisor
    always_comb
    begin
        bit_idx = cnt_reg - CNT_W'(1);
        trial   = {rem_reg, NUM_LOW[bit_idx]};
        ge      = (trial >= {1'b0, den_reg});
    end

    // Step the division
    always_comb
    begin
        rem_next  = rem_reg;
        den_next  = den_reg;
        quo_next  = quo_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            rem_next  = DEN_W'(PERIOD_NUM[NUM_W-1:QUO_W]);
            den_next  = den;
            quo_next  = '0;
            cnt_next  = CNT_W'(QUO_W);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            rem_next = ge ? DEN_W'(trial - {1'b0, den_reg}) : trial[DEN_W-1:0];
            quo_next = {quo_reg[QUO_W-2:0], ge};
            cnt_next = cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // Hold control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    // Hold datapath
    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        den_reg <= den_next;
        quo_reg <= quo_next;
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign quotient  = quo_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/distance_to_tone_period_core.sv =====
// ----------------------------------------------------------------------------
// Distance to tone period - core
// Turns a hand distance and temperature into a speaker timer period,
// a duty compare value and the note within the selected key.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready) carries distance_inches and temperature.
//   Output channel (out_valid/out_ready) carries one result per input.
//   Configuration channel (cfg_valid/cfg_ready, cfg_index, cfg_data) writes
//   key_select (index 0) and volume_fraction (index 1); it is always ready.
//   An in-range distance with non-zero temperature steps through MUL_BR,
//   MUL_T, DIV_GO, DIV_WAIT, MUL_V and LOAD; any other input goes straight
//   to MUL_V and LOAD. The divider produces one quotient bit per cycle; the
//   shared multiplier is registered and forms each of its three products.
//   in_ready is high only while the sequencer is idle, so one item is in
//   work at a time. A finished result sits in the output register; the next
//   input is taken while it waits, and a new result holds in the sequencer
//   until the receiver takes the previous one.
//   Reset: key A, volume 128/256, stored previous distance 0, no result.
// ----------------------------------------------------------------------------
`default_nettype none

module distance_to_tone_period_core (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  logic [7:0]                       distance_inches,
    input  logic [6:0]                       temperature,
    output logic                             out_valid,
    input  logic                             out_ready,
    output logic [15:0]                      tone_period,
    output logic [15:0]                      duty_compare,
    output logic [2:0]                       scale_degree,
    output logic [3:0]                       note_in_key,
    output logic                             in_range,
    output logic                             pitch_changed,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [dtp_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [dtp_pkg::CFG_DATA_W-1:0]   cfg_data
);
    import dtp_pkg::*;

    state_t state_reg, state_next;

    logic [3:0]  key_reg,    key_next;
    logic [8:0]  vol_reg,    vol_next;
    logic [7:0]  prev_reg,   prev_next;
    logic [3:0]  keff_reg,   keff_next;
    logic [3:0]  step_reg,   step_next;
    logic [6:0]  temp_reg,   temp_next;
    logic [2:0]  degree_reg, degree_next;
    logic [3:0]  note_reg,   note_next;
    logic        inr_reg,    inr_next;
    logic        chg_reg,    chg_next;
    logic [15:0] period_reg, period_next;

    logic        out_valid_reg, out_valid_next;
    logic [15:0] o_period_reg,  o_period_next;
    logic [15:0] o_duty_reg,    o_duty_next;
    logic [2:0]  o_degree_reg,  o_degree_next;
    logic [3:0]  o_note_reg,    o_note_next;
    logic        o_inr_reg,     o_inr_next;
    logic        o_chg_reg,     o_chg_next;

    logic               mul_en;
    logic [MUL_A_W-1:0] mul_a;
    logic [MUL_B_W-1:0] mul_b;
    logic [MUL_P_W-1:0] mul_p;

    logic               div_start;
    div_stat_t          div_stat;
    logic [QUO_W-1:0]   div_q;

    logic        in_fire;
    logic        cfg_fire;
    logic        win;
    logic [2:0]  degree_c;
    logic [3:0]  step_c;
    logic [3:0]  keff_c;
    logic [4:0]  note_sum;
    logic [3:0]  note_c;

    assign in_ready  = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign in_fire   = in_valid && in_ready;
    assign cfg_fire  = cfg_valid && cfg_ready;

    // Decode the incoming distance into degree, step and note
    always_comb
    begin
        win      = (distance_inches >= LOW_DISTANCE) && (distance_inches <= HIGH_DISTANCE);
        degree_c = 3'(distance_inches - LOW_DISTANCE);
        step_c   = degree_step(degree_c);
        keff_c   = (key_reg < 4'(NUM_KEYS)) ? key_reg : 4'd0;
        note_sum = {1'b0, keff_c} + {1'b0, step_c};
        note_c   = (note_sum >= 5'(NUM_KEYS)) ? 4'(note_sum - 5'(NUM_KEYS))
                                               : note_sum[3:0];
    end

    // Select multiplier operands for the current step
    always_comb
    begin
        mul_en = 1'b0;
        mul_a  = '0;
        mul_b  = '0;
        unique case (state_reg)
            ST_MUL_BR:
            begin
                mul_en = 1'b1;
                mul_a  = MUL_A_W'(base_rom(keff_reg));
                mul_b  = ratio_rom(step_reg);
            end
            ST_MUL_T:
            begin
                mul_en = 1'b1;
                mul_a  = mul_p[MUL_A_W-1:0];
                mul_b  = MUL_B_W'(temp_reg);
            end
            ST_MUL_V:
            begin
                mul_en = 1'b1;
                mul_a  = MUL_A_W'(period_reg);
                mul_b  = MUL_B_W'(vol_reg);
            end
            default:
            begin
                mul_en = 1'b0;
            end
        endcase
    end

    // Sequencer: next state, working registers and output register
    always_comb
    begin
        state_next     = state_reg;
        key_next       = key_reg;
        vol_next       = vol_reg;
        prev_next      = prev_reg;
        keff_next      = keff_reg;
        step_next      = step_reg;
        temp_next      = temp_reg;
        degree_next    = degree_reg;
        note_next      = note_reg;
        inr_next       = inr_reg;
        chg_next       = chg_reg;
        period_next    = period_reg;
        out_valid_next = out_valid_reg;
        o_period_next  = o_period_reg;
        o_duty_next    = o_duty_reg;
        o_degree_next  = o_degree_reg;
        o_note_next    = o_note_reg;
        o_inr_next     = o_inr_reg;
        o_chg_next     = o_chg_reg;
        div_start      = 1'b0;

        // Apply configuration writes
        if (cfg_fire)
        begin
            unique case (cfg_index)
                CFG_KEY_SELECT: key_next = cfg_data[3:0];
                CFG_VOLUME:     vol_next = cfg_data;
                default:        vol_next = vol_reg;
            endcase
        end

        // Drop the result once the receiver takes it
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    chg_next  = (distance_inches != prev_reg);
                    temp_next = temperature;
                    keff_next = keff_c;
                    step_next = step_c;
                    inr_next  = win;
                    if (win)
                    begin
                        prev_next   = distance_inches;
                        degree_next = degree_c;
                        note_next   = note_c;
                        if (temperature == 7'd0)
                        begin
                            period_next = PERIOD_MAX;
                            state_next  = ST_MUL_V;
                        end
                        else
                        begin
                            state_next = ST_MUL_BR;
                        end
                    end
                    else
                    begin
                        prev_next   = 8'd0;
                        degree_next = 3'd0;
                        note_next   = 4'd0;
                        period_next = 16'd0;
                        state_next  = ST_MUL_V;
                    end
                end
            end
            ST_MUL_BR:
            begin
                state_next = ST_MUL_T;
            end
            ST_MUL_T:
            begin
                state_next = ST_DIV_GO;
            end
            ST_DIV_GO:
            begin
                div_start  = 1'b1;
                state_next = ST_DIV_WAIT;
            end
            ST_DIV_WAIT:
            begin
                if (div_stat.done)
                begin
                    period_next = (|div_q[QUO_W-1:16]) ? PERIOD_MAX : div_q[15:0];
                    state_next  = ST_MUL_V;
                end
            end
            ST_MUL_V:
            begin
                state_next = ST_LOAD;
            end
            ST_LOAD:
            begin
                // Load the result once the output register is free
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next = 1'b1;
                    o_period_next  = period_reg;
                    o_duty_next    = mul_p[24] ? PERIOD_MAX : mul_p[23:8];
                    o_degree_next  = degree_reg;
                    o_note_next    = note_reg;
                    o_inr_next     = inr_reg;
                    o_chg_next     = chg_reg;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Hold control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            key_reg       <= 4'd0;
            vol_reg       <= VOLUME_RESET;
            prev_reg      <= 8'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            key_reg       <= key_next;
            vol_reg       <= vol_next;
            prev_reg      <= prev_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Hold working and result payload
    always_ff @(posedge clk)
    begin
        keff_reg     <= keff_next;
        step_reg     <= step_next;
        temp_reg     <= temp_next;
        degree_reg   <= degree_next;
        note_reg     <= note_next;
        inr_reg      <= inr_next;
        chg_reg      <= chg_next;
        period_reg   <= period_next;
        o_period_reg <= o_period_next;
        o_duty_reg   <= o_duty_next;
        o_degree_reg <= o_degree_next;
        o_note_reg   <= o_note_next;
        o_inr_reg    <= o_inr_next;
        o_chg_reg    <= o_chg_next;
    end

    dtp_mul u_mul (
        .clk   (clk),
        .en    (mul_en),
        .op_a  (mul_a),
        .op_b  (mul_b),
        .prod  (mul_p)
    );

    dtp_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .den      (mul_p[DEN_W-1:0]),
        .stat     (div_stat),
        .quotient (div_q)
    );

    assign out_valid     = out_valid_reg;
    assign tone_period   = o_period_reg;
    assign duty_compare  = o_duty_reg;
    assign scale_degree  = o_degree_reg;
    assign note_in_key   = o_note_reg;
    assign in_range      = o_inr_reg;
    assign pitch_changed = o_chg_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/dtp_checker.sv =====
// ----------------------------------------------------------------------------
// Distance to tone period - port checker
// Port-level properties of the tone period core, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "distance_to_tone_period_core_defines.svh"

module dtp_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic        in_ready,
    input  logic        out_valid,
    input  logic        out_ready,
    input  logic [15:0] tone_period,
    input  logic [15:0] duty_compare,
    input  logic [2:0]  scale_degree,
    input  logic [3:0]  note_in_key,
    input  logic        in_range,
    input  logic        pitch_changed
);

    // The core works on one item at a time
    `DTP_ASSERT_NEXT(a_busy_after_accept, clk, rst_n, in_valid && in_ready, !in_ready, "input taken while an item is in work")

    // A stalled result holds its period, duty compare and pitch-change flag
    `DTP_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(tone_period) && $stable(duty_compare) && $stable(pitch_changed), "stalled result changed")

    // Out-of-range results are silent and carry no note
    `DTP_ASSERT_NOW(a_silent, clk, rst_n, out_valid && !in_range, tone_period == 16'd0 && duty_compare == 16'd0 && scale_degree == 3'd0 && note_in_key == 4'd0, "out-of-range result not silent")

    // The note always wraps inside one octave
    `DTP_ASSERT_NOW(a_note_wrap, clk, rst_n, out_valid, note_in_key < 4'd12, "note not wrapped modulo 12")

endmodule

bind distance_to_tone_period_core dtp_checker u_dtp_checker (.*);

`default_nettype wire
